FILE: src/wildcard_byte_pattern_matcher_assert.svh
// Assertion macros shared by the checker of the wildcard byte pattern matcher.
`ifndef WILDCARD_BYTE_PATTERN_MATCHER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define WBPM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define WBPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/wbpm_pkg.sv
// Package of shared constants and types for the wildcard byte pattern matcher.
`default_nettype none

package wbpm_pkg;

   // Pattern registers hold sixteen bytes.
   localparam int PATTERN_REG_BYTES   = 16;
   localparam int MAX_PATTERN_DEFAULT = 16;

   // Field widths.
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 64;
   localparam int LENGTH_W   = 5;
   localparam int LIMIT_W    = 16;
   localparam int MASK_W     = 16;
   localparam int PATTERN_W  = PATTERN_REG_BYTES * BYTE_W;

   // Register port.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;

   // Reset values of the registers.
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 5'd1;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd100;

   // Register indexes; each register sits at byte address 8 * index.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_WILDCARD     = 3'd2,
      REG_LENGTH       = 3'd3,
      REG_LIMIT        = 3'd4
   } csr_reg_type;

endpackage

`default_nettype wire

FILE: src/wbpm_window_compare.sv
// Parallel comparison of the byte window against the pattern and wildcard mask.
`default_nettype none

module wbpm_window_compare #(
   parameter int CAP = 16
) (
   input  wire logic [CAP-1:0][wbpm_pkg::BYTE_W-1:0] hist_bytes,
   input  wire logic [wbpm_pkg::PATTERN_W-1:0]       pattern,
   input  wire logic [wbpm_pkg::MASK_W-1:0]          wildcard_mask,
   input  wire logic [wbpm_pkg::LENGTH_W-1:0]        length,
   output logic                                      hit
);
   import wbpm_pkg::*;

   logic [CAP-1:0] pos_ok;

   // Position i is compared with the byte of age (length - 1 - i), the newest
   // byte having age zero. Unused and wildcard positions always agree.
   always_comb begin
      pos_ok = '1;
      for (int i = 0; i < CAP; i++) begin
         if (!wildcard_mask[i] && (LENGTH_W'(i) < length)) begin
            pos_ok[i] = 1'b0;
            for (int a = 0; a < CAP; a++) begin
               if ((length == LENGTH_W'(i + a + 1)) &&
                   (hist_bytes[a] == pattern[i*BYTE_W +: BYTE_W])) begin
                  pos_ok[i] = 1'b1;
               end
            end
         end
      end
   end

   assign hit = &pos_ok;

endmodule

`default_nettype wire

FILE: src/wildcard_byte_pattern_matcher.sv
// Top level of the wildcard byte pattern matcher: registers, window and result stage.
//
// Usage: bytes of memory sections arrive on the req_ channel, one word per cycle
// while req_ready is high, each with its address and a flag marking the first
// byte of a section. Every byte enters a shift register of the most recent bytes;
// the window is compared against the configured pattern and a hit below the
// result limit produces one word on the rsp_ channel carrying the start address
// of the match and a flag set on the match that reaches the result limit. Bytes
// that do not complete a match produce no word. A result passes from the window
// register through the compare to the output register. Throughput: one byte per
// cycle while the output register is not stalled, set by the single compare
// stage between the window register and the output register.
// Stalls: while rsp_ready is low the result waits in the output register; one
// more byte may be taken into the window stage, after which req_ready drops.
// Reset clears the window fill count, the match counter, both valid flags and
// the registers (pattern length returns to 1, result limit to 100).
// The register port is APB-style with 64-bit data, registers at 8-byte steps;
// write it only while the block is idle.
`default_nettype none

module wildcard_byte_pattern_matcher #(
   parameter int MAX_PATTERN = wbpm_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Byte input channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [wbpm_pkg::BYTE_W-1:0]     req_data_byte,
   input  wire logic [wbpm_pkg::ADDR_W-1:0]     req_byte_address,
   input  wire logic                            req_section_first,
   // Match result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [wbpm_pkg::ADDR_W-1:0]          rsp_match_address,
   output logic                                 rsp_limit_reached,
   // Register port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [wbpm_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [wbpm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [wbpm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import wbpm_pkg::*;

   // Longest usable pattern: bounded by the parameter and the register bytes.
   localparam int CAP = (MAX_PATTERN < PATTERN_REG_BYTES) ? MAX_PATTERN : PATTERN_REG_BYTES;
   localparam logic [LENGTH_W-1:0] CAP_LEN = LENGTH_W'(CAP);

   // Configuration registers
   logic [ADDR_W-1:0]   pattern_low_ff, pattern_low_in;
   logic [ADDR_W-1:0]   pattern_high_ff, pattern_high_in;
   logic [MASK_W-1:0]   wildcard_ff, wildcard_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;

   // Window stage
   logic [CAP-1:0][BYTE_W-1:0] hist_ff, hist_in;
   logic [LENGTH_W-1:0]        count_ff, count_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;

   // Result stage
   logic [LIMIT_W-1:0] matches_ff, matches_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic               rsp_limit_ff, rsp_limit_in;

   logic                csr_write;
   csr_reg_type         csr_idx;
   logic                req_fire;
   logic                s1_fire;
   logic [LENGTH_W-1:0] len_eff;
   logic                can_report;
   logic                hit;
   logic                produce;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = csr_reg_type'(paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W]);

   // Register writes
   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      wildcard_in     = wildcard_ff;
      length_in       = length_ff;
      limit_in        = limit_ff;
      if (csr_write) begin
         unique case (csr_idx)
            REG_PATTERN_LOW:  pattern_low_in  = pwdata;
            REG_PATTERN_HIGH: pattern_high_in = pwdata;
            REG_WILDCARD:     wildcard_in     = pwdata[MASK_W-1:0];
            REG_LENGTH:       length_in       = pwdata[LENGTH_W-1:0];
            REG_LIMIT:        limit_in        = pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_idx)
         REG_PATTERN_LOW:  prdata = pattern_low_ff;
         REG_PATTERN_HIGH: prdata = pattern_high_ff;
         REG_WILDCARD:     prdata = CSR_DATA_W'(wildcard_ff);
         REG_LENGTH:       prdata = CSR_DATA_W'(length_ff);
         REG_LIMIT:        prdata = CSR_DATA_W'(limit_ff);
         default:          prdata = '0;
      endcase
   end

   // Handshakes: the window stage moves on when the output register is free.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // Window update: the new byte becomes the newest entry and the fill count
   // restarts at a section boundary, saturating at the usable maximum.
   always_comb begin
      hist_in     = hist_ff;
      count_in    = count_ff;
      addr_in     = addr_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
         addr_in     = req_byte_address;
         hist_in[0]  = req_data_byte;
         for (int k = 1; k < CAP; k++) begin
            hist_in[k] = hist_ff[k-1];
         end
         if (req_section_first) begin
            count_in = LENGTH_W'(1);
         end else if (count_ff >= CAP_LEN) begin
            count_in = CAP_LEN;
         end else begin
            count_in = count_ff + LENGTH_W'(1);
         end
      end
   end

   // Compare the window against the pattern.
   assign len_eff = (length_ff > CAP_LEN) ? CAP_LEN : length_ff;

   wbpm_window_compare #(
      .CAP (CAP)
   ) u_compare (
      .hist_bytes    (hist_ff),
      .pattern       ({pattern_high_ff, pattern_low_ff}),
      .wildcard_mask (wildcard_ff),
      .length        (len_eff),
      .hit           (hit)
   );

   assign can_report = (len_eff != '0) && (count_ff >= len_eff) && (matches_ff < limit_ff);
   assign produce    = s1_fire && can_report && hit;

   // Result register and match counter.
   always_comb begin
      matches_in   = matches_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_limit_in = rsp_limit_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (produce) begin
         matches_in   = matches_ff + LIMIT_W'(1);
         rsp_valid_in = 1'b1;
         rsp_addr_in  = addr_ff - ADDR_W'(len_eff - LENGTH_W'(1));
         rsp_limit_in = (matches_ff + LIMIT_W'(1)) == limit_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         wildcard_ff     <= '0;
         length_ff       <= LENGTH_RESET;
         limit_ff        <= LIMIT_RESET;
         count_ff        <= '0;
         s1_valid_ff     <= 1'b0;
         matches_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         wildcard_ff     <= wildcard_in;
         length_ff       <= length_in;
         limit_ff        <= limit_in;
         count_ff        <= count_in;
         s1_valid_ff     <= s1_valid_in;
         matches_ff      <= matches_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hist_ff      <= hist_in;
      addr_ff      <= addr_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_limit_ff <= rsp_limit_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_address = rsp_addr_ff;
   assign rsp_limit_reached = rsp_limit_ff;

endmodule

`default_nettype wire

FILE: src/wbpm_checker.sv
// Port-level checker for the wildcard byte pattern matcher, bound to the top level.
`default_nettype none

`include "wildcard_byte_pattern_matcher_assert.svh"

module wbpm_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [wbpm_pkg::ADDR_W-1:0]     rsp_match_address,
   input wire logic                            rsp_limit_reached,
   input wire logic                            psel,
   input wire logic                            penable,
   input wire logic                            pready
);

   // A stalled result word keeps its payload.
   `WBPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_match_address) && $stable(rsp_limit_reached), "result word changed while stalled")

   // Reset empties the output register.
   `WBPM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result word present after reset")

   // A result word that raises rsp_valid follows a byte accepted into the window register.
   `WBPM_ASSERT_IMPLY(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result word without a byte two cycles before")

   // The register port never inserts wait states.
   `WBPM_ASSERT_IMPLY(a_pready_high, clock, reset, psel && penable, pready, "register access stalled")

endmodule

bind wildcard_byte_pattern_matcher wbpm_checker u_wbpm_checker (.*);

`default_nettype wire

FILE: verif/tb_wildcard_byte_pattern_matcher.sv
// Self-checking testbench for the wildcard byte pattern matcher, with driver, monitor and predictor.
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_matcher;
   import wbpm_pkg::*;

   localparam int WINDOW_DEPTH = 15;
   localparam int LONGEST      = 16;
   localparam int DRAIN_CYCLES = 6;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASES       = 9;
   localparam int PHASE_BYTES  = 42;

   // One input word and one result word.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [ADDR_W-1:0] byte_address;
      logic              section_first;
   } byte_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0] match_address;
      logic              limit_reached;
   } match_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_data_byte     = '0;
   logic [ADDR_W-1:0]     req_byte_address  = '0;
   logic                  req_section_first = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic [ADDR_W-1:0]     rsp_match_address;
   logic                  rsp_limit_reached;
   logic                  psel              = 1'b0;
   logic                  penable           = 1'b0;
   logic                  pwrite            = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr             = '0;
   logic [CSR_DATA_W-1:0] pwdata            = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   wildcard_byte_pattern_matcher dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_byte_address  (req_byte_address),
      .req_section_first (req_section_first),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_match_address (rsp_match_address),
      .rsp_limit_reached (rsp_limit_reached),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register copies held by the predictor.
   logic [63:0]         cfg_pattern_low  = '0;
   logic [63:0]         cfg_pattern_high = '0;
   logic [MASK_W-1:0]   cfg_wildcard     = '0;
   logic [LENGTH_W-1:0] cfg_length       = LENGTH_RESET;
   logic [LIMIT_W-1:0]  cfg_limit        = LIMIT_RESET;

   // Predictor state: previous bytes of the section, newest first.
   logic [BYTE_W-1:0] recent_bytes [WINDOW_DEPTH];
   int                section_fill = 0;
   int                matches_so_far = 0;

   byte_word_type  byte_queue [$];
   match_word_type expected_matches [$];
   byte_word_type  in_flight;
   match_word_type predicted_hit;
   match_word_type oldest_match;

   int send_gap       = 0;
   int send_gap_max   = 0;
   int recv_stall     = 0;
   int recv_stall_max = 0;
   int error_count    = 0;
   int quiet_cycles   = 0;

   initial begin
      foreach (recent_bytes[i]) recent_bytes[i] = '0;
   end

   function automatic int effective_length();
      return (cfg_length > 5'd16) ? LONGEST : int'(cfg_length);
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_byte(input int pos);
      logic [63:0] half;
      half = (pos < 8) ? cfg_pattern_low : cfg_pattern_high;
      return half[(pos % 8) * 8 +: 8];
   endfunction

   // Advances the window by one byte; returns 1 when the byte completes a match.
   function automatic bit predict_match(input byte_word_type w, output match_word_type m);
      int             len;
      int             fill;
      int             age;
      int             i;
      bit             hit;
      logic [BYTE_W-1:0] seen;
      len = effective_length();
      hit = 1'b0;
      m   = '0;
      if (w.section_first) begin
         foreach (recent_bytes[k]) recent_bytes[k] = '0;
         section_fill = 0;
      end
      fill = (section_fill + 1 > LONGEST) ? LONGEST : section_fill + 1;
      if (len >= 1 && fill >= len && matches_so_far < int'(cfg_limit)) begin
         hit = 1'b1;
         for (i = 0; i < len; i++) begin
            age  = len - 1 - i;
            seen = (age == 0) ? w.data_byte : recent_bytes[age - 1];
            if (!cfg_wildcard[i] && seen != pattern_byte(i)) hit = 1'b0;
         end
         if (hit) begin
            matches_so_far++;
            m.match_address = w.byte_address - ADDR_W'(len - 1);
            m.limit_reached = (matches_so_far >= int'(cfg_limit));
         end
      end
      for (i = WINDOW_DEPTH - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i - 1];
      recent_bytes[0] = w.data_byte;
      section_fill = fill;
      return hit;
   endfunction

   // Driver: presents queued bytes, holding each until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (predict_match(in_flight, predicted_hit)) expected_matches.push_back(predicted_hit);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               in_flight = byte_queue.pop_front();
               req_valid         <= 1'b1;
               req_data_byte     <= in_flight.data_byte;
               req_byte_address  <= in_flight.byte_address;
               req_section_first <= in_flight.section_first;
               send_gap = $urandom_range(0, send_gap_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each match word with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_matches.size() == 0) begin
               $error("unexpected match word at address %h", rsp_match_address);
               error_count++;
            end else begin
               oldest_match = expected_matches.pop_front();
               if (rsp_match_address !== oldest_match.match_address) begin
                  $error("match_address: expected %h, actual %h",
                         oldest_match.match_address, rsp_match_address);
                  error_count++;
               end
               if (rsp_limit_reached !== oldest_match.limit_reached) begin
                  $error("limit_reached: expected %b, actual %b",
                         oldest_match.limit_reached, rsp_limit_reached);
                  error_count++;
               end
            end
            recv_stall = $urandom_range(0, recv_stall_max);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One register write: setup cycle, then access cycle until pready.
   task automatic csr_write(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_PATTERN_LOW:  cfg_pattern_low  = value;
         REG_PATTERN_HIGH: cfg_pattern_high = value;
         REG_WILDCARD:     cfg_wildcard     = value[MASK_W-1:0];
         REG_LENGTH:       cfg_length       = value[LENGTH_W-1:0];
         REG_LIMIT:        cfg_limit        = value[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input logic [63:0] low, input logic [63:0] high,
                                 input logic [MASK_W-1:0] mask,
                                 input logic [LENGTH_W-1:0] len,
                                 input logic [LIMIT_W-1:0] limit);
      csr_write(REG_PATTERN_LOW, low);
      csr_write(REG_PATTERN_HIGH, high);
      csr_write(REG_WILDCARD, 64'(mask));
      csr_write(REG_LENGTH, 64'(len));
      csr_write(REG_LIMIT, 64'(limit));
   endtask

   // Waits until every queued byte is taken and every predicted match has
   // arrived, then lets bytes without a match leave the pipeline.
   task automatic drain_matches();
      do @(posedge clock);
      while (byte_queue.size() != 0 || req_valid || expected_matches.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic [ADDR_W-1:0] addr,
                             input logic first);
      byte_word_type w;
      w.data_byte     = b;
      w.byte_address  = addr;
      w.section_first = first;
      byte_queue.push_back(w);
   endtask

   // A section of consecutive bytes with copies of the pattern planted in
   // random content; noisy sections scatter addresses and section starts.
   task automatic queue_section(input int n, input bit noisy);
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] b;
      int                len;
      int                plant_left;
      int                pos;
      int                i;
      addr = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0) addr = '1 - ADDR_W'($urandom_range(0, 20));
      len = effective_length();
      if (len == 0) len = 1;
      plant_left = 0;
      for (i = 0; i < n; i++) begin
         if (noisy) begin
            b = 8'($urandom);
            if ($urandom_range(0, 1) == 0) addr = {$urandom, $urandom};
            queue_byte(b, addr, $urandom_range(0, 3) == 0);
         end else begin
            if (plant_left == 0 && $urandom_range(0, 3) == 0) plant_left = len;
            if (plant_left > 0) begin
               pos = len - plant_left;
               b = cfg_wildcard[pos] ? 8'($urandom) : pattern_byte(pos);
               plant_left--;
            end else if ($urandom_range(0, 1) == 0) begin
               b = pattern_byte($urandom_range(0, len - 1));
            end else begin
               b = 8'($urandom);
            end
            queue_byte(b, addr, i == 0);
         end
         addr = addr + 1'b1;
      end
   endtask

   // Stimulus: directed cases first, then phases of random sections.
   initial begin
      int                 phase;
      int                 phase_bytes;
      int                 n;
      logic [LENGTH_W-1:0] len;
      logic [MASK_W-1:0]   mask;
      logic [LIMIT_W-1:0]  limit;
      logic [63:0]         low;
      logic [63:0]         high;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a one-byte pattern of zero.
      queue_byte(8'h00, '0, 1'b1);
      queue_byte(8'hFF, '1, 1'b0);
      queue_byte(8'h00, '1, 1'b0);
      drain_matches();

      // Three-byte pattern with a wildcard in the middle, limit two matches away.
      write_settings(64'h0000_0000_0033_AA11, '1, 16'h0002, 5'd3,
                     LIMIT_W'(matches_so_far + 2));
      send_gap_max   = 2;
      recv_stall_max = 2;
      // The match starts just below the top of the address space and wraps.
      queue_byte(8'h11, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
      queue_byte(8'h99, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      queue_byte(8'h33, 64'h0, 1'b0);
      // A match straddling a section boundary must not be reported.
      queue_byte(8'h11, 64'h1, 1'b0);
      queue_byte(8'h44, 64'h100, 1'b1);
      queue_byte(8'h33, 64'h101, 1'b0);
      // This one reaches the limit and carries the flag.
      queue_byte(8'h11, 64'h102, 1'b0);
      queue_byte(8'h77, 64'h103, 1'b0);
      queue_byte(8'h33, 64'h104, 1'b0);
      // Beyond the limit: nothing reported.
      queue_byte(8'h11, 64'h105, 1'b0);
      queue_byte(8'h00, 64'h106, 1'b0);
      queue_byte(8'h33, 64'h107, 1'b0);
      drain_matches();

      // Raising the limit resumes reporting.
      csr_write(REG_LIMIT, 64'(matches_so_far + 1));
      queue_byte(8'h11, 64'h108, 1'b0);
      queue_byte(8'h5A, 64'h109, 1'b0);
      queue_byte(8'h33, 64'h10A, 1'b0);
      drain_matches();

      // Random phases, each under its own settings.
      for (phase = 0; phase < PHASES; phase++) begin
         low   = {$urandom, $urandom};
         high  = {$urandom, $urandom};
         mask  = 16'($urandom & $urandom & $urandom);
         len   = 5'($urandom_range(1, 16));
         limit = '1;
         case (phase)
            0: mask = '0;
            1: begin
               len  = 5'd31;
               mask = '1;
            end
            2: len = '0;
            3: limit = LIMIT_W'((matches_so_far + 3 > 65535) ? 65535 : matches_so_far + 3);
            4: limit = '0;
            5: begin
               len  = 5'd1;
               low  = '1;
               mask = '0;
            end
            6: len = 5'($urandom_range(17, 31));
            default: ;
         endcase
         write_settings(low, high, mask, len, limit);

         // Alternate between busy stretches and heavy idling on both sides.
         case ($urandom_range(0, 2))
            0: send_gap_max = 0;
            1: send_gap_max = 3;
            default: send_gap_max = 16;
         endcase
         case ($urandom_range(0, 2))
            0: recv_stall_max = 0;
            1: recv_stall_max = 3;
            default: recv_stall_max = 16;
         endcase

         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 24);
            queue_section(n, $urandom_range(0, 4) == 0);
            phase_bytes += n;
         end
         drain_matches();
      end

      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
